[src/bcss_pkg.sv]
package bcss_pkg;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned VEL_W     = 24;
  localparam int unsigned ACC_W     = 24;
  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 24;

  // Working widths: a velocity sum needs one extra bit, its square twice that.
  localparam int unsigned VSUM_W = VEL_W + 1;
  localparam int unsigned SQ_W   = 2 * VSUM_W;
  localparam int unsigned REM_W  = VSUM_W + 1;
  localparam int unsigned CMP_W  = VSUM_W + 3;
  localparam int unsigned CNT_W  = 5;

  localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(VSUM_W);
  localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(SPEED_W);

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_MIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_MAX    = 2'd2;

  localparam logic [SPEED_W-1:0]    SPEED_RST     = 16'd256;
  localparam logic signed [ACC_W-1:0] ACC_MIN_RST = -24'sd12800;
  localparam logic signed [ACC_W-1:0] ACC_MAX_RST = 24'sd12800;

  typedef struct packed {
    logic start;
    logic div_mode;
  } bcss_req_t;

  function automatic logic [VSUM_W-1:0] bcss_mag(logic signed [VSUM_W-1:0] v);
    logic signed [VSUM_W-1:0] n;
    n = -v;
    return v[VSUM_W-1] ? unsigned'(n) : unsigned'(v);
  endfunction

endpackage

[src/bcss_if.sv]
interface bcss_in_if import bcss_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           command;
  logic signed [ACC_W-1:0]    in_accel_x;
  logic signed [ACC_W-1:0]    in_accel_y;
  logic signed [POS_W-1:0]    in_pos_x;
  logic signed [POS_W-1:0]    in_pos_y;
  logic signed [VEL_W-1:0]    in_vel_x;
  logic signed [VEL_W-1:0]    in_vel_y;

  modport source (output valid, command, in_accel_x, in_accel_y, in_pos_x, in_pos_y,
                  in_vel_x, in_vel_y, input ready);
  modport sink (input valid, command, in_accel_x, in_accel_y, in_pos_x, in_pos_y,
                in_vel_x, in_vel_y, output ready);
endinterface

interface bcss_out_if import bcss_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [POS_W-1:0]    out_pos_x;
  logic signed [POS_W-1:0]    out_pos_y;
  logic signed [VEL_W-1:0]    out_vel_x;
  logic signed [VEL_W-1:0]    out_vel_y;
  logic                       zero_velocity;

  modport source (output valid, out_pos_x, out_pos_y, out_vel_x, out_vel_y, zero_velocity,
                  input ready);
  modport sink (input valid, out_pos_x, out_pos_y, out_vel_x, out_vel_y, zero_velocity,
                output ready);
endinterface

[src/bcss_sqdiv.sv]
module bcss_sqdiv import bcss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bcss_req_t         req_i,
  input  logic [SQ_W-1:0]   src_i,
  input  logic [VSUM_W-1:0] dvs_i,
  output logic              done_o,
  output logic [VSUM_W-1:0] res_o
);

  logic              busy_q, busy_d;
  logic              div_q, div_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [VSUM_W-1:0] root_q, root_d;
  logic [SQ_W-1:0]   src_q, src_d;
  logic [VSUM_W-1:0] dvs_q, dvs_d;
  logic [CMP_W-1:0]  shifted, trial, diff;
  logic              ge;

  // One compare-subtract serves both the root digit and the quotient digit.
  always_comb begin
    shifted = div_q ? {1'b0, rem_q, src_q[SQ_W-1]} : {rem_q, src_q[SQ_W-1 -: 2]};
    trial   = div_q ? {3'b000, dvs_q} : {1'b0, root_q, 2'b01};
    ge      = shifted >= trial;
    diff    = shifted - trial;
  end

  always_comb begin
    busy_d = busy_q;
    div_d  = div_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    root_d = root_q;
    src_d  = src_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      div_d  = req_i.div_mode;
      root_d = '0;
      dvs_d  = dvs_i;
      if (req_i.div_mode) begin
        cnt_d = DIV_STEPS;
        rem_d = {1'b0, src_i[SPEED_W +: VSUM_W]};
        src_d = {src_i[SPEED_W-1:0], (SQ_W - SPEED_W)'(0)};
      end else begin
        cnt_d = SQRT_STEPS;
        rem_d = '0;
        src_d = src_i;
      end
    end else if (busy_q) begin
      rem_d  = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
      root_d = {root_q[VSUM_W-2:0], ge};
      src_d  = div_q ? {src_q[SQ_W-2:0], 1'b0} : {src_q[SQ_W-3:0], 2'b00};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      div_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      div_q  <= div_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    src_q  <= src_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign res_o  = root_q;

endmodule

[src/boid_constant_speed_step_core.sv]
// A load or tick result beat comes after the bit-serial square root (25 steps) and two
// 16-step divisions on one shared unit.
// A zero velocity skips the divisions; other commands go straight to the output state.
// One item at a time: a new input beat is taken only once the last result has entered
// the output register, so a stall on the result side holds it off.
// Reset is asynchronous and active low; it clears the agent state and loads register defaults.
module boid_constant_speed_step_core import bcss_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bcss_in_if.sink              in_i,
  bcss_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SQX   = 4'd1;
  localparam logic [3:0] ST_SQY   = 4'd2;
  localparam logic [3:0] ST_ROOT  = 4'd3;
  localparam logic [3:0] ST_RWAIT = 4'd4;
  localparam logic [3:0] ST_MULX  = 4'd5;
  localparam logic [3:0] ST_DIVX  = 4'd6;
  localparam logic [3:0] ST_DWX   = 4'd7;
  localparam logic [3:0] ST_MULY  = 4'd8;
  localparam logic [3:0] ST_DIVY  = 4'd9;
  localparam logic [3:0] ST_DWY   = 4'd10;
  localparam logic [3:0] ST_OUT   = 4'd11;

  logic [3:0] state_q;

  logic [SPEED_W-1:0]        speed_q;
  logic signed [ACC_W-1:0]   acc_min_q, acc_max_q;

  logic signed [POS_W-1:0]   pos_x_q, pos_y_q;
  logic signed [VEL_W-1:0]   vel_x_q, vel_y_q;
  logic signed [ACC_W-1:0]   acc_x_q, acc_y_q;
  logic                      flag_q;

  logic signed [VSUM_W-1:0]  vx_q, vy_q;
  logic [SQ_W-1:0]           prod_q, sum_q;
  logic [VSUM_W-1:0]         m_q;
  logic [SPEED_W-1:0]        qx_q;

  logic                      ovalid_q;
  logic signed [POS_W-1:0]   opos_x_q, opos_y_q;
  logic signed [VEL_W-1:0]   ovel_x_q, ovel_y_q;
  logic                      oflag_q;

  logic                      in_fire, out_free;
  logic [VSUM_W-1:0]         mag_x, mag_y, mul_a, mul_b;
  logic [SQ_W-1:0]           prod_d;
  bcss_req_t                 req;
  logic [SQ_W-1:0]           unit_src;
  logic                      unit_done;
  logic [VSUM_W-1:0]         unit_res;
  logic [SPEED_W-1:0]        q_y;
  logic signed [VEL_W-1:0]   qx_pos, qx_neg, qy_pos, qy_neg;

  function automatic logic signed [ACC_W-1:0] clamp(logic signed [ACC_W-1:0] a,
                                                    logic signed [ACC_W-1:0] b,
                                                    logic signed [ACC_W-1:0] lo,
                                                    logic signed [ACC_W-1:0] hi);
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
    if (s < (ACC_W+1)'(lo)) begin
      return lo;
    end else if (s > (ACC_W+1)'(hi)) begin
      return hi;
    end
    return s[ACC_W-1:0];
  endfunction

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !ovalid_q || out_o.ready;

  assign mag_x = bcss_mag(vx_q);
  assign mag_y = bcss_mag(vy_q);

  always_comb begin
    case (state_q)
      ST_SQX:  begin mul_a = mag_x; mul_b = mag_x; end
      ST_SQY:  begin mul_a = mag_y; mul_b = mag_y; end
      ST_MULX: begin mul_a = mag_x; mul_b = VSUM_W'(speed_q); end
      default: begin mul_a = mag_y; mul_b = VSUM_W'(speed_q); end
    endcase
    prod_d = SQ_W'(mul_a) * SQ_W'(mul_b);
  end

  always_comb begin
    req.start    = (state_q == ST_ROOT) || (state_q == ST_DIVX) || (state_q == ST_DIVY);
    req.div_mode = (state_q != ST_ROOT);
    unit_src     = (state_q == ST_ROOT) ? (sum_q + prod_q) : prod_q;
  end

  bcss_sqdiv u_sqdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .src_i  (unit_src),
    .dvs_i  (m_q),
    .done_o (unit_done),
    .res_o  (unit_res)
  );

  assign q_y    = unit_res[SPEED_W-1:0];
  assign qx_pos = VEL_W'(qx_q);
  assign qx_neg = -qx_pos;
  assign qy_pos = VEL_W'(q_y);
  assign qy_neg = -qy_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q   <= SPEED_RST;
      acc_min_q <= ACC_MIN_RST;
      acc_max_q <= ACC_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TARGET_SPEED: speed_q   <= cfg_wdata_i[SPEED_W-1:0];
        REG_ACCEL_MIN:    acc_min_q <= signed'(cfg_wdata_i[ACC_W-1:0]);
        REG_ACCEL_MAX:    acc_max_q <= signed'(cfg_wdata_i[ACC_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      vel_x_q  <= '0;
      vel_y_q  <= '0;
      acc_x_q  <= '0;
      acc_y_q  <= '0;
      flag_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if ((state_q == ST_OUT) && out_free) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            flag_q <= 1'b0;
            case (in_i.command)
              CMD_LOAD: begin
                acc_x_q <= in_i.in_accel_x;
                acc_y_q <= in_i.in_accel_y;
                pos_x_q <= in_i.in_pos_x;
                pos_y_q <= in_i.in_pos_y;
                state_q <= ST_SQX;
              end
              CMD_ADD: begin
                acc_x_q <= clamp(acc_x_q, in_i.in_accel_x, acc_min_q, acc_max_q);
                acc_y_q <= clamp(acc_y_q, in_i.in_accel_y, acc_min_q, acc_max_q);
                state_q <= ST_OUT;
              end
              CMD_TICK: begin
                pos_x_q <= pos_x_q + POS_W'(vel_x_q);
                pos_y_q <= pos_y_q + POS_W'(vel_y_q);
                state_q <= ST_SQX;
              end
              default: state_q <= ST_OUT;
            endcase
          end
        end
        ST_SQX:  state_q <= ST_SQY;
        ST_SQY:  state_q <= ST_ROOT;
        ST_ROOT: state_q <= ST_RWAIT;
        ST_RWAIT: begin
          if (unit_done) begin
            if (unit_res == '0) begin
              vel_x_q <= '0;
              vel_y_q <= '0;
              flag_q  <= 1'b1;
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_MULX;
            end
          end
        end
        ST_MULX: state_q <= ST_DIVX;
        ST_DIVX: state_q <= ST_DWX;
        ST_DWX: begin
          if (unit_done) begin
            state_q <= ST_MULY;
          end
        end
        ST_MULY: state_q <= ST_DIVY;
        ST_DIVY: state_q <= ST_DWY;
        ST_DWY: begin
          if (unit_done) begin
            vel_x_q <= vx_q[VSUM_W-1] ? qx_neg : qx_pos;
            vel_y_q <= vy_q[VSUM_W-1] ? qy_neg : qy_pos;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (in_i.command == CMD_LOAD) begin
        vx_q <= VSUM_W'(in_i.in_vel_x);
        vy_q <= VSUM_W'(in_i.in_vel_y);
      end else begin
        vx_q <= VSUM_W'(vel_x_q) + VSUM_W'(acc_x_q);
        vy_q <= VSUM_W'(vel_y_q) + VSUM_W'(acc_y_q);
      end
    end
    if (state_q == ST_SQY) begin
      sum_q <= prod_q;
    end
    prod_q <= prod_d;
    if ((state_q == ST_RWAIT) && unit_done) begin
      m_q <= unit_res;
    end
    if ((state_q == ST_DWX) && unit_done) begin
      qx_q <= unit_res[SPEED_W-1:0];
    end
    if ((state_q == ST_OUT) && out_free) begin
      opos_x_q <= pos_x_q;
      opos_y_q <= pos_y_q;
      ovel_x_q <= vel_x_q;
      ovel_y_q <= vel_y_q;
      oflag_q  <= flag_q;
    end
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.out_pos_x     = opos_x_q;
  assign out_o.out_pos_y     = opos_y_q;
  assign out_o.out_vel_x     = ovel_x_q;
  assign out_o.out_vel_y     = ovel_y_q;
  assign out_o.zero_velocity = oflag_q;

endmodule

[src/bcss_checker.sv]
module bcss_checker import bcss_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic signed [POS_W-1:0] out_pos_x_i,
  input logic signed [VEL_W-1:0] out_vel_x_i,
  input logic signed [VEL_W-1:0] out_vel_y_i,
  input logic                 zero_velocity_i
);

  // A stalled result beat keeps its valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its x position and x velocity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_pos_x_i) && $stable(out_vel_x_i))
    else $error("result payload changed while stalled");

  // The block works on one item at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while an item is in progress");

  // A zero-velocity result carries a zero velocity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && zero_velocity_i |-> (out_vel_x_i == '0) && (out_vel_y_i == '0))
    else $error("zero-velocity flag with nonzero velocity");

endmodule

bind boid_constant_speed_step_core bcss_checker u_bcss_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_pos_x_i     (out_o.out_pos_x),
  .out_vel_x_i     (out_o.out_vel_x),
  .out_vel_y_i     (out_o.out_vel_y),
  .zero_velocity_i (out_o.zero_velocity)
);

[verif/tb_boid_constant_speed_step_core.sv]
module tb_boid_constant_speed_step_core import bcss_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0]       CMD_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0]   REG_UNUSED  = 2'd3;
  localparam logic signed [ACC_W-1:0] ACC_TOP    = 24'sh7FFFFF;
  localparam logic signed [ACC_W-1:0] ACC_BOTTOM = 24'sh800000;
  localparam logic signed [POS_W-1:0] POS_TOP    = 32'sh7FFFFFFF;
  localparam logic signed [POS_W-1:0] POS_BOTTOM = 32'sh80000000;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [ACC_W-1:0] accel_x;
    logic signed [ACC_W-1:0] accel_y;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
  } agent_cmd_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic                    zero_vel;
  } agent_view_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DAT_W-1:0] cfg_wdata_i;

  bcss_in_if  in_if ();
  bcss_out_if out_if ();

  boid_constant_speed_step_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Predicted agent state and register copies.
  logic [SPEED_W-1:0]      speed_reg = SPEED_RST;
  logic signed [ACC_W-1:0] accel_lo  = ACC_MIN_RST;
  logic signed [ACC_W-1:0] accel_hi  = ACC_MAX_RST;
  logic [POS_W-1:0]        agent_px  = '0;
  logic [POS_W-1:0]        agent_py  = '0;
  logic signed [VEL_W-1:0] agent_vx  = '0;
  logic signed [VEL_W-1:0] agent_vy  = '0;
  logic signed [ACC_W-1:0] agent_ax  = '0;
  logic signed [ACC_W-1:0] agent_ay  = '0;

  agent_view_t expected_views[$];
  int unsigned cmd_count [2**CMD_W];
  int unsigned results_seen = 0;
  int unsigned zero_flags   = 0;
  int unsigned reg_writes   = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  int          stall_left   = 0;
  bit          steady       = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 25; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic logic signed [VEL_W-1:0] scale_axis(longint sv, longint unsigned norm);
    longint unsigned mag;
    longint unsigned q;
    logic [VEL_W-1:0] qv;
    mag = (sv < 0) ? -sv : sv;
    q = (mag * speed_reg) / norm;
    qv = VEL_W'(q);
    return (sv < 0) ? -qv : qv;
  endfunction

  function automatic void retarget(input longint sum_x, input longint sum_y,
                                   output logic stalled);
    longint unsigned mag_x;
    longint unsigned mag_y;
    longint unsigned norm;
    mag_x = (sum_x < 0) ? -sum_x : sum_x;
    mag_y = (sum_y < 0) ? -sum_y : sum_y;
    norm = floor_sqrt(mag_x * mag_x + mag_y * mag_y);
    stalled = (norm == 0);
    if (stalled) begin
      agent_vx = '0;
      agent_vy = '0;
    end else begin
      agent_vx = scale_axis(sum_x, norm);
      agent_vy = scale_axis(sum_y, norm);
    end
  endfunction

  function automatic logic signed [ACC_W-1:0] clamp_accel(longint s);
    if (s < longint'(accel_lo)) return accel_lo;
    if (s > longint'(accel_hi)) return accel_hi;
    return ACC_W'(s);
  endfunction

  function automatic agent_view_t advance_agent(agent_cmd_t c);
    agent_view_t v;
    logic signed [POS_W-1:0] step_x;
    logic signed [POS_W-1:0] step_y;
    logic stalled;
    stalled = 1'b0;
    case (c.command)
      CMD_LOAD: begin
        agent_ax = c.accel_x;
        agent_ay = c.accel_y;
        agent_px = c.pos_x;
        agent_py = c.pos_y;
        retarget(longint'(c.vel_x), longint'(c.vel_y), stalled);
      end
      CMD_ADD: begin
        agent_ax = clamp_accel(longint'(agent_ax) + longint'(c.accel_x));
        agent_ay = clamp_accel(longint'(agent_ay) + longint'(c.accel_y));
      end
      CMD_TICK: begin
        step_x = agent_vx;
        step_y = agent_vy;
        agent_px = agent_px + step_x;
        agent_py = agent_py + step_y;
        retarget(longint'(agent_vx) + longint'(agent_ax),
                 longint'(agent_vy) + longint'(agent_ay), stalled);
      end
      default: ;
    endcase
    v.pos_x = agent_px;
    v.pos_y = agent_py;
    v.vel_x = agent_vx;
    v.vel_y = agent_vy;
    v.zero_vel = stalled;
    return v;
  endfunction

  function automatic int pick_gap();
    int unsigned pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  function automatic logic signed [ACC_W-1:0] random_s24();
    int unsigned pick;
    logic signed [ACC_W-1:0] raw;
    pick = $urandom_range(0, 99);
    raw = ACC_W'($urandom);
    if (pick < 10) begin
      case ($urandom_range(0, 4))
        0: return ACC_TOP;
        1: return ACC_BOTTOM;
        2: return '0;
        3: return 24'sd1;
        default: return -24'sd1;
      endcase
    end
    if (pick < 40) return raw;
    return raw >>> $urandom_range(4, 21);
  endfunction

  function automatic logic signed [POS_W-1:0] random_pos32();
    case ($urandom_range(0, 19))
      0: return POS_TOP;
      1: return POS_BOTTOM;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic agent_cmd_t make_cmd(input logic [CMD_W-1:0] cmd,
                                          input logic signed [ACC_W-1:0] ax, ay,
                                          input logic signed [POS_W-1:0] px, py,
                                          input logic signed [VEL_W-1:0] vx, vy);
    agent_cmd_t c;
    c.command = cmd;
    c.accel_x = ax;
    c.accel_y = ay;
    c.pos_x = px;
    c.pos_y = py;
    c.vel_x = vx;
    c.vel_y = vy;
    return c;
  endfunction

  function automatic agent_cmd_t random_item(bit force_load);
    agent_cmd_t c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    c.command = (force_load || pick < 8) ? CMD_LOAD :
                (pick < 45) ? CMD_ADD : (pick < 97) ? CMD_TICK : CMD_UNUSED;
    c.accel_x = random_s24();
    c.accel_y = random_s24();
    c.pos_x = random_pos32();
    c.pos_y = random_pos32();
    c.vel_x = random_s24();
    c.vel_y = random_s24();
    if (c.command == CMD_LOAD && $urandom_range(0, 15) == 0) begin
      c.vel_x = '0;
      c.vel_y = '0;
    end
    return c;
  endfunction

  task automatic report_mismatch(string what, logic [POS_W-1:0] got, logic [POS_W-1:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("[%0t] mismatch at result beat %0d: %s got %h, expected %h",
               $time, results_seen, what, got, want);
  endtask

  task automatic check_result();
    agent_view_t want;
    results_seen++;
    if (expected_views.size() == 0) begin
      report_mismatch("beat with no expected result", '0, '0);
      return;
    end
    want = expected_views.pop_front();
    if (out_if.out_pos_x !== want.pos_x) report_mismatch("out_pos_x", out_if.out_pos_x, want.pos_x);
    if (out_if.out_pos_y !== want.pos_y) report_mismatch("out_pos_y", out_if.out_pos_y, want.pos_y);
    if (out_if.out_vel_x !== want.vel_x) report_mismatch("out_vel_x", out_if.out_vel_x, want.vel_x);
    if (out_if.out_vel_y !== want.vel_y) report_mismatch("out_vel_y", out_if.out_vel_y, want.vel_y);
    if (out_if.zero_velocity !== want.zero_vel)
      report_mismatch("zero_velocity", out_if.zero_velocity, want.zero_vel);
    if (want.zero_vel) zero_flags++;
  endtask

  task automatic send_item(agent_cmd_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.command    <= c.command;
    in_if.in_accel_x <= c.accel_x;
    in_if.in_accel_y <= c.accel_y;
    in_if.in_pos_x   <= c.pos_x;
    in_if.in_pos_y   <= c.pos_y;
    in_if.in_vel_x   <= c.vel_x;
    in_if.in_vel_y   <= c.vel_y;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_views.push_back(advance_agent(c));
    cmd_count[c.command]++;
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_TARGET_SPEED: speed_reg = data[SPEED_W-1:0];
      REG_ACCEL_MIN:    accel_lo = data;
      REG_ACCEL_MAX:    accel_hi = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic apply_config(logic [SPEED_W-1:0] speed, logic signed [ACC_W-1:0] lo,
                              logic signed [ACC_W-1:0] hi);
    logic [CFG_DAT_W-1:0] word;
    settle();
    word = $urandom;
    word[SPEED_W-1:0] = speed;
    write_reg(REG_TARGET_SPEED, word);
    write_reg(REG_ACCEL_MIN, lo);
    write_reg(REG_ACCEL_MAX, hi);
  endtask

  task automatic run_traffic(int unsigned count);
    send_item(random_item(1'b1));
    for (int unsigned n = 1; n < count; n++) send_item(random_item(1'b0));
  endtask

  task automatic test_reset_defaults();
    send_item(make_cmd(CMD_TICK, '0, '0, '0, '0, '0, '0));
    send_item(make_cmd(CMD_UNUSED, ACC_TOP, ACC_BOTTOM, POS_TOP, POS_BOTTOM, ACC_TOP, ACC_BOTTOM));
    send_item(make_cmd(CMD_ADD, 24'sd300, -24'sd300, '0, '0, '0, '0));
    send_item(make_cmd(CMD_TICK, '0, '0, '0, '0, '0, '0));
  endtask

  task automatic test_load_extremes();
    send_item(make_cmd(CMD_LOAD, '0, '0, POS_TOP, POS_BOTTOM, ACC_TOP, ACC_BOTTOM));
    send_item(make_cmd(CMD_TICK, '0, '0, '0, '0, '0, '0));
    send_item(make_cmd(CMD_LOAD, '0, '0, POS_BOTTOM, -32'sd1, '0, '0));
    send_item(make_cmd(CMD_TICK, '0, '0, '0, '0, '0, '0));
    send_item(make_cmd(CMD_UNUSED, -24'sd7, 24'sd9, 32'sd5, -32'sd5, 24'sd3, -24'sd3));
  endtask

  task automatic test_tick_overflow();
    apply_config(16'hFFFF, ACC_MIN_RST, ACC_MAX_RST);
    send_item(make_cmd(CMD_LOAD, ACC_TOP, ACC_BOTTOM, 32'sd256, -32'sd256, ACC_TOP, '0));
    send_item(make_cmd(CMD_TICK, '0, '0, '0, '0, '0, '0));
    send_item(make_cmd(CMD_LOAD, ACC_BOTTOM, ACC_BOTTOM, '0, '0, ACC_BOTTOM, ACC_BOTTOM));
    send_item(make_cmd(CMD_TICK, '0, '0, '0, '0, '0, '0));
    send_item(make_cmd(CMD_LOAD, -24'sd65535, '0, '0, '0, 24'sd1000, '0));
    send_item(make_cmd(CMD_TICK, '0, '0, '0, '0, '0, '0));
  endtask

  task automatic test_accel_clamp();
    apply_config(SPEED_RST, ACC_BOTTOM, ACC_TOP);
    send_item(make_cmd(CMD_ADD, ACC_TOP, ACC_BOTTOM, '0, '0, '0, '0));
    send_item(make_cmd(CMD_ADD, ACC_TOP, ACC_BOTTOM, '0, '0, '0, '0));
    apply_config(SPEED_RST, 24'sd100, -24'sd100);
    send_item(make_cmd(CMD_ADD, '0, '0, '0, '0, '0, '0));
    send_item(make_cmd(CMD_ADD, 24'sd500, -24'sd500, '0, '0, '0, '0));
    settle();
    write_reg(REG_UNUSED, 24'hABCDEF);
    send_item(make_cmd(CMD_ADD, '0, '0, '0, '0, '0, '0));
    apply_config(SPEED_RST, ACC_MIN_RST, ACC_MAX_RST);
    send_item(make_cmd(CMD_ADD, 24'sd20000, -24'sd20000, '0, '0, '0, '0));
  endtask

  task automatic test_speed_extremes();
    apply_config('0, ACC_MIN_RST, ACC_MAX_RST);
    send_item(make_cmd(CMD_LOAD, 24'sd40, 24'sd0, 32'sd1, 32'sd2, 24'sd5, 24'sd5));
    send_item(make_cmd(CMD_TICK, '0, '0, '0, '0, '0, '0));
    apply_config(16'd1, ACC_MIN_RST, ACC_MAX_RST);
    send_item(make_cmd(CMD_LOAD, '0, '0, '0, '0, 24'sd3, 24'sd4));
    send_item(make_cmd(CMD_TICK, '0, '0, '0, '0, '0, '0));
  endtask

  task automatic test_random_default();
    apply_config(SPEED_RST, ACC_MIN_RST, ACC_MAX_RST);
    run_traffic(250);
  endtask

  task automatic test_random_limits();
    int lim;
    lim = $urandom_range(1, 400000);
    apply_config(SPEED_W'($urandom_range(1, 65535)), ACC_W'(-lim), ACC_W'(lim));
    run_traffic(200);
  endtask

  task automatic test_back_to_back();
    settle();
    steady = 1'b1;
    apply_config(SPEED_W'($urandom), random_s24(), random_s24());
    run_traffic(150);
    settle();
    steady = 1'b0;
  endtask

  task automatic test_drain_pause();
    apply_config(SPEED_W'($urandom_range(200, 4000)), ACC_MIN_RST, ACC_MAX_RST);
    for (int unsigned burst = 0; burst < 3; burst++) begin
      run_traffic(50);
      settle();
    end
  endtask

  task automatic test_random_extreme_config();
    apply_config(16'hFFFF, ACC_BOTTOM, ACC_TOP);
    run_traffic(150);
    apply_config(SPEED_W'($urandom_range(0, 64)), ACC_TOP, ACC_BOTTOM);
    run_traffic(100);
    apply_config('0, ACC_MIN_RST, ACC_MAX_RST);
    run_traffic(50);
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) check_result();
      if (stall_left > 0) stall_left--;
      else stall_left = pick_gap();
      out_if.ready <= (stall_left == 0);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Run stopped by the watchdog after %0d cycles.", cycle_count);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= REG_TARGET_SPEED;
    cfg_wdata_i      <= '0;
    in_if.valid      <= 1'b0;
    in_if.command    <= CMD_LOAD;
    in_if.in_accel_x <= '0;
    in_if.in_accel_y <= '0;
    in_if.in_pos_x   <= '0;
    in_if.in_pos_y   <= '0;
    in_if.in_vel_x   <= '0;
    in_if.in_vel_y   <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_load_extremes();
    test_tick_overflow();
    test_accel_clamp();
    test_speed_extremes();
    test_random_default();
    test_random_limits();
    test_back_to_back();
    test_drain_pause();
    test_random_extreme_config();

    settle();
    repeat (100) @(posedge clk_i);
    if (expected_views.size() != 0)
      report_mismatch("results never delivered", expected_views.size(), '0);
    $display("Sent %0d loads, %0d acceleration adds, %0d ticks, %0d unused commands; %0d reg writes.",
             cmd_count[CMD_LOAD], cmd_count[CMD_ADD], cmd_count[CMD_TICK], cmd_count[CMD_UNUSED],
             reg_writes);
    $display("Compared %0d result beats, %0d of them with the zero-velocity flag set.",
             results_seen, zero_flags);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
